@@ sv/spct_pkg.sv @@
`default_nettype none
package spct_pkg;
  localparam int CoordBits = 16;
  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [CoordBits:0] diff_t;
  typedef logic signed [2*CoordBits+1:0] prod_t;
  typedef logic signed [2*CoordBits+3:0] acc_t;

  typedef enum logic [2:0] {
    ACT_PT_RECT   = 3'd0,
    ACT_PT_CIRC   = 3'd1,
    ACT_SEG_SEG   = 3'd2,
    ACT_CIRC_CIRC = 3'd3,
    ACT_RECT_RECT = 3'd4,
    ACT_CIRC_SEG  = 3'd5,
    ACT_RECT_CIRC = 3'd6
  } action_t;
endpackage
`default_nettype wire

@@ sv/spct_mul.sv @@
`default_nettype none
// registered signed multiplier with enable
module spct_mul import spct_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire diff_t a,
  input  wire diff_t b,
  output prod_t      p
);
  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod_t'(a) * prod_t'(b);
    end
  end
endmodule
`default_nettype wire

@@ sv/shape_pair_collision_test_top.sv @@
`default_nettype none
// output word valid once the accepted input word has passed six register stages (stage 1 to stage 6)
// throughput: one word per cycle unless stalled; the 33x33 compare in circle-segment sets the depth
// stall freezes every stage together; output register holds until taken
// reset (rst, synchronous) clears all valid bits; data registers are not reset
module shape_pair_collision_test_top import spct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [2:0] action,
  input  wire coord_t a_x,
  input  wire coord_t a_y,
  input  wire coord_t a_u,
  input  wire coord_t a_v,
  input  wire coord_t b_x,
  input  wire coord_t b_y,
  input  wire coord_t b_u,
  input  wire coord_t b_v,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      hit
);
  localparam int NumStg = 6;
  localparam int ProdW = 2*CoordBits+2;
  localparam int CrW = 2*CoordBits+1;
  localparam int R2W = 2*CoordBits-1;
  localparam int DdW = 2*CoordBits+1;

  logic [NumStg-1:0] vld;
  logic adv;
  assign adv = !(vld[NumStg-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NumStg-1];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStg-2:0], in_valid};
    end
  end

  // stage 1: differences and rect compares
  logic [2:0] act1;
  diff_t d [7];
  logic sim1, rr1, bu_nn1;
  logic signed [CoordBits+1:0] lx1, hx1, ly1, hy1, bx1, by1;
  always_ff @(posedge clk) begin
    if (adv) begin
      act1 <= action;
      // stage-1 operands for the multipliers
      case (action)
        ACT_SEG_SEG: begin
          d[0] <= a_u - a_x; d[1] <= b_y - a_y; d[2] <= a_v - a_y; d[3] <= b_x - a_x;
          d[4] <= b_u - b_x; d[5] <= b_v - b_y;
        end
        ACT_CIRC_SEG: begin
          d[0] <= a_x - b_x; d[1] <= a_y - b_y; d[2] <= b_u - b_x; d[3] <= b_v - b_y;
          d[4] <= a_x - b_u; d[5] <= a_y - b_v;
        end
        default: begin
          d[0] <= a_x - b_x; d[1] <= a_y - b_y;
          d[2] <= (action == ACT_CIRC_CIRC) ? diff_t'(a_u) + diff_t'(b_u) : diff_t'(b_u);
          d[3] <= '0; d[4] <= '0; d[5] <= '0;
        end
      endcase
      d[6] <= diff_t'(a_u);
      sim1 <= !((diff_t'(a_x) > diff_t'(b_x) + diff_t'(b_u)) || (a_x < b_x) ||
                (diff_t'(a_y) > diff_t'(b_y) + diff_t'(b_v)) || (a_y < b_y));
      rr1 <= (diff_t'(a_x) < diff_t'(b_x) + diff_t'(b_u)) &&
             (diff_t'(a_x) + diff_t'(a_u) > diff_t'(b_x)) &&
             (diff_t'(a_y) < diff_t'(b_y) + diff_t'(b_v)) &&
             (diff_t'(a_y) + diff_t'(a_v) > diff_t'(b_y));
      bu_nn1 <= !b_u[CoordBits-1];
      lx1 <= a_x; hx1 <= a_x + a_u; ly1 <= a_y; hy1 <= a_y + a_v;
      bx1 <= b_x; by1 <= b_y;
    end
  end

  // stage 2: rect-circle clamp folded into e[7], e[8]
  logic [2:0] act2;
  diff_t e [9];
  logic sim2, rr2, bu_nn2;
  logic signed [CoordBits+1:0] px, py, qx, qy;
  always_comb begin
    px = bx1; if (px < lx1) px = lx1; if (px > hx1) px = hx1;
    py = by1; if (py < ly1) py = ly1; if (py > hy1) py = hy1;
    qx = px - bx1;
    qy = py - by1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      act2 <= act1; sim2 <= sim1; rr2 <= rr1; bu_nn2 <= bu_nn1;
      for (int i = 0; i < 7; i++) e[i] <= d[i];
      // out of the 17-bit range: saturate to the most negative value, no radius can reach that far
      e[7] <= (qx[CoordBits+1] != qx[CoordBits]) ? {1'b1, {CoordBits{1'b0}}} :
                                                   qx[CoordBits:0];
      e[8] <= (qy[CoordBits+1] != qy[CoordBits]) ? {1'b1, {CoordBits{1'b0}}} :
                                                   qy[CoordBits:0];
    end
  end

  // stage 3: products
  diff_t ma [8], mb [8];
  prod_t p [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin ma[i] = '0; mb[i] = '0; end
    case (act2)
      ACT_SEG_SEG: begin
        ma[0] = e[0]; mb[0] = e[1]; ma[1] = e[2]; mb[1] = e[3];
        ma[2] = e[4]; mb[2] = e[1]; ma[3] = e[5]; mb[3] = e[3];
        ma[4] = e[2]; mb[4] = e[4]; ma[5] = e[0]; mb[5] = e[5];
      end
      ACT_CIRC_SEG: begin
        ma[0] = e[0]; mb[0] = e[0]; ma[1] = e[1]; mb[1] = e[1];
        ma[2] = e[2]; mb[2] = e[2]; ma[3] = e[3]; mb[3] = e[3];
        ma[4] = e[0]; mb[4] = e[2]; ma[5] = e[1]; mb[5] = e[3];
        ma[6] = e[4]; mb[6] = e[4]; ma[7] = e[5]; mb[7] = e[5];
      end
      ACT_RECT_CIRC: begin
        ma[0] = e[7]; mb[0] = e[7]; ma[1] = e[8]; mb[1] = e[8];
        ma[2] = e[2]; mb[2] = e[2];
      end
      default: begin
        ma[0] = e[0]; mb[0] = e[0]; ma[1] = e[1]; mb[1] = e[1];
        ma[2] = e[2]; mb[2] = e[2];
      end
    endcase
  end
  for (genvar g = 0; g < 8; g++) begin : g_mul
    spct_mul u_mul (.clk(clk), .en(adv), .a(ma[g]), .b(mb[g]), .p(p[g]));
  end
  logic [2:0] act3;
  logic sim3, rr3, bu_nn3;
  diff_t cx3, sx3, cy3, dx3, dy3;
  always_ff @(posedge clk) begin
    if (adv) begin
      act3 <= act2; sim3 <= sim2; rr3 <= rr2; bu_nn3 <= bu_nn2;
      sx3 <= e[0]; cy3 <= e[1]; dx3 <= e[2]; dy3 <= e[3];
      // circle-seg: radius kept in e[6]
      cx3 <= e[6];
    end
  end

  // stage 4: sums, cross product and r^2 (second multiply round)
  logic [2:0] act4;
  logic sim4, rr4, bu_nn4;
  acc_t s0, s2, es, dd, sd, na, nb, den;
  prod_t cr_a, cr_b, r2;
  always_ff @(posedge clk) begin
    if (adv) begin
      act4 <= act3; sim4 <= sim3; rr4 <= rr3; bu_nn4 <= bu_nn3;
      s0 <= acc_t'(p[0]) + acc_t'(p[1]);
      s2 <= acc_t'(p[2]);
      na <= acc_t'(p[0]) - acc_t'(p[1]);
      nb <= acc_t'(p[2]) - acc_t'(p[3]);
      den <= acc_t'(p[4]) - acc_t'(p[5]);
      dd <= acc_t'(p[2]) + acc_t'(p[3]);
      sd <= acc_t'(p[4]) + acc_t'(p[5]);
      es <= acc_t'(p[6]) + acc_t'(p[7]);
      r2 <= prod_t'(cx3) * prod_t'(cx3);
      cr_a <= prod_t'(sx3) * prod_t'(dy3);
      cr_b <= prod_t'(cy3) * prod_t'(dx3);
    end
  end

  // stage 5: cross magnitude and wide compare operands
  // cross = sxv*dy - syv*dx; only its magnitude matters
  logic [2:0] act5;
  logic [CrW-1:0] ucr;
  logic [R2W-1:0] ur2;
  logic [DdW-1:0] udd;
  logic h_simple5, h_seg5, h_cs_far5, h_cs_near5;
  logic sel_far5, sel_near5, dd0_5;
  logic signed [ProdW+1:0] crs, crs_abs;
  always_comb begin
    crs = (ProdW+2)'(cr_b) - (ProdW+2)'(cr_a);
    crs_abs = crs[ProdW+1] ? -crs : crs;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      act5 <= act4;
      ucr <= crs_abs[CrW-1:0];
      ur2 <= r2[R2W-1:0];
      udd <= dd[DdW-1:0];
      dd0_5 <= (dd == 0);
      sel_far5 <= sd > dd;
      sel_near5 <= sd < 0;
      h_cs_far5 <= es <= acc_t'(r2);
      h_cs_near5 <= s0 <= acc_t'(r2);
      if (den == 0) h_seg5 <= (na == 0) && (nb == 0);
      else if (den > 0) h_seg5 <= na >= 0 && na <= den && nb >= 0 && nb <= den;
      else h_seg5 <= na <= 0 && na >= den && nb <= 0 && nb >= den;
      case (act4)
        ACT_PT_RECT:   h_simple5 <= sim4;
        ACT_PT_CIRC,
        ACT_CIRC_CIRC: h_simple5 <= s0 < s2;
        ACT_RECT_RECT: h_simple5 <= rr4;
        ACT_RECT_CIRC: h_simple5 <= bu_nn4 && (s0 <= s2);
        default:       h_simple5 <= 1'b0;
      endcase
    end
  end

  // stage 6: wide squares compared, final select into output register
  logic [2*CrW-1:0] lhs;
  logic [R2W+DdW-1:0] rhs;
  always_comb begin
    lhs = ucr * ucr;
    rhs = ur2 * udd;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      case (act5)
        ACT_SEG_SEG:  hit <= h_seg5;
        ACT_CIRC_SEG: hit <= (dd0_5 || sel_near5) ? h_cs_near5 :
                             sel_far5 ? h_cs_far5 : (lhs <= rhs);
        default:      hit <= h_simple5;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ bench/collision_checker.sv @@
module collision_checker import spct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic [2:0] action,
  input  wire coord_t a_x,
  input  wire coord_t a_y,
  input  wire coord_t a_u,
  input  wire coord_t a_v,
  input  wire coord_t b_x,
  input  wire coord_t b_y,
  input  wire coord_t b_u,
  input  wire coord_t b_v,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic hit,
  output int        fail_count,
  output int        pending_hits
);
  bit expected_hits[$];

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // segment pair crossing with sign-aware parameter bounds
  function automatic bit segments_cross(longint ax, longint ay, longint au, longint av,
                                        longint bx, longint by, longint bu, longint bv);
    longint na, nb, den;
    na = (au - ax) * (by - ay) - (av - ay) * (bx - ax);
    nb = (bu - bx) * (by - ay) - (bv - by) * (bx - ax);
    den = (av - ay) * (bu - bx) - (au - ax) * (bv - by);
    if (den == 0) return na == 0 && nb == 0;
    if (den > 0) return na >= 0 && na <= den && nb >= 0 && nb <= den;
    return na <= 0 && na >= den && nb <= 0 && nb >= den;
  endfunction

  // circle against segment; perpendicular case compared as 128-bit squares
  function automatic bit circle_touches_segment(longint cx, longint cy, longint r,
                                                longint fx, longint fy,
                                                longint tx, longint ty);
    longint sxv, syv, dx, dy, r2, dd, sd, cr;
    logic [127:0] lhs, rhs;
    sxv = cx - fx; syv = cy - fy; dx = tx - fx; dy = ty - fy;
    r2 = r * r;
    dd = dx * dx + dy * dy;
    if (dd == 0) return sxv * sxv + syv * syv <= r2;
    sd = sxv * dx + syv * dy;
    if (sd > dd) return (cx - tx) * (cx - tx) + (cy - ty) * (cy - ty) <= r2;
    if (sd < 0) return sxv * sxv + syv * syv <= r2;
    cr = sxv * dy - syv * dx;
    if (cr < 0) cr = -cr;
    lhs = 128'(cr) * 128'(cr);
    rhs = 128'(r2) * 128'(dd);
    return lhs <= rhs;
  endfunction

  function automatic bit collides(logic [2:0] act, longint ax, longint ay, longint au,
                                  longint av, longint bx, longint by, longint bu,
                                  longint bv);
    longint px, py, rs;
    case (act)
      ACT_PT_RECT: return !(ax > bx + bu || ax < bx || ay > by + bv || ay < by);
      ACT_PT_CIRC: return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) < bu * bu;
      ACT_SEG_SEG: return segments_cross(ax, ay, au, av, bx, by, bu, bv);
      ACT_CIRC_CIRC: begin
        rs = au + bu;
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by) < rs * rs;
      end
      ACT_RECT_RECT: return ax < bx + bu && ax + au > bx && ay < by + bv && ay + av > by;
      ACT_CIRC_SEG: return circle_touches_segment(ax, ay, au, bx, by, bu, bv);
      ACT_RECT_CIRC: begin
        px = clamp_to(bx, ax, ax + au);
        py = clamp_to(by, ay, ay + av);
        return bu >= 0 && (px - bx) * (px - bx) + (py - by) * (py - by) <= bu * bu;
      end
      default: return 1'b0;
    endcase
  endfunction

  assign pending_hits = expected_hits.size();

  // predict on accepted input word, compare on accepted output word
  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_hits.push_back(collides(action, a_x, a_y, a_u, a_v, b_x, b_y, b_u, b_v));
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $error("hit: unexpected word, actual %0d", hit);
          fail_count <= fail_count + 1;
        end else if (expected_hits[0] !== hit) begin
          $error("hit: expected %0d actual %0d", expected_hits[0], hit);
          fail_count <= fail_count + 1;
          void'(expected_hits.pop_front());
        end else begin
          void'(expected_hits.pop_front());
        end
      end
    end
  end
endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import spct_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  coord_t a_x = '0, a_y = '0, a_u = '0, a_v = '0;
  coord_t b_x = '0, b_y = '0, b_u = '0, b_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  int fail_count, pending_hits;
  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  shape_pair_collision_test_top dut (.*);

  collision_checker checker_i (.*);

  // receiver stall pattern
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  // drive one word and hold until accepted
  task automatic send_word(logic [2:0] act, coord_t ax, coord_t ay, coord_t au, coord_t av,
                           coord_t bx, coord_t by, coord_t bu, coord_t bv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    a_x <= ax; a_y <= ay; a_u <= au; a_v <= av;
    b_x <= bx; b_y <= by; b_u <= bu; b_v <= bv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [2:0] act;
    for (int i = 0; i < count; i++) begin
      act = 3'($urandom_range(6));
      send_word(act, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners per test
    send_word(ACT_PT_RECT, 0, 0, 0, 0, 0, 0, 10, 10);
    send_word(ACT_PT_RECT, 10, 10, 0, 0, 0, 0, 10, 10);
    send_word(ACT_PT_RECT, 5, 5, 0, 0, 0, 0, -10, -10);
    send_word(ACT_PT_CIRC, 3, 4, 0, 0, 0, 0, 5, 0);
    send_word(ACT_PT_CIRC, 3, 3, 0, 0, 0, 0, -5, 0);
    send_word(ACT_SEG_SEG, 0, 0, 10, 10, 0, 10, 10, 0);
    send_word(ACT_SEG_SEG, 0, 0, 10, 0, 0, 5, 10, 5);
    send_word(ACT_SEG_SEG, 0, 0, 10, 0, 5, 0, 20, 0);
    send_word(ACT_CIRC_CIRC, 0, 0, 3, 0, 5, 0, 2, 0);
    send_word(ACT_CIRC_CIRC, 0, 0, -3, 0, 4, 0, -2, 0);
    send_word(ACT_RECT_RECT, 0, 0, 10, 10, 10, 0, 5, 5);
    send_word(ACT_RECT_RECT, 0, 0, 10, 10, 5, 5, 10, 10);
    send_word(ACT_CIRC_SEG, 5, 5, 2, 0, 3, 5, 3, 5);
    send_word(ACT_CIRC_SEG, 0, 5, 5, 0, -10, 0, 10, 0);
    send_word(ACT_CIRC_SEG, 20, 0, 3, 0, 0, 0, 10, 0);
    send_word(ACT_CIRC_SEG, 16'sh7fff, 16'sh8000, 16'sh7fff, 0,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_word(ACT_RECT_CIRC, 0, 0, 10, 10, 13, 14, 5, 0);
    send_word(ACT_RECT_CIRC, 0, 0, 10, 10, 5, 5, -1, 0);
    send_word(ACT_RECT_CIRC, 0, 0, -10, -10, 5, 5, 3, 0);
    send_word(ACT_RECT_CIRC, 16'sh8000, 0, 16'sh8000, 10, 16'sh7fff, 5, 16'sh7fff, 0);
    send_word(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(ACT_RECT_RECT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_word(ACT_SEG_SEG, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    // hold off until the pipeline drains
    in_valid <= 1'b0;
    while (pending_hits != 0) @(negedge clk);
    send_random(180);
    send_idle_pct = 84;
    send_random(170);
    send_idle_pct = 0; recv_stall_pct = 84;
    send_random(170);
    send_idle_pct = 23; recv_stall_pct = 23;
    send_random(170);
    in_valid <= 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    wait_cycles = 0;
    while (pending_hits != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_hits == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/spct_pkg.sv
sv/spct_mul.sv
sv/shape_pair_collision_test_top.sv
bench/collision_checker.sv
bench/tb_top.sv
